// File: sv/i2cebw_pkg.sv
package i2cebw_pkg;

  localparam logic [6:0] DEV_SEL_RESET = 7'd80;
  localparam logic       WRITE_BIT     = 1'b0;
  localparam int unsigned BITS_PER_BYTE = 8;

  // Command kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_NONE = 2'd0;
  localparam logic [1:0] STATUS_DONE = 2'd1;
  localparam logic [1:0] STATUS_NACK = 2'd2;

  // Byte slots of one transfer
  localparam logic [1:0] SLOT_DEVICE  = 2'd0;
  localparam logic [1:0] SLOT_ADDR_HI = 2'd1;
  localparam logic [1:0] SLOT_ADDR_LO = 2'd2;
  localparam logic [1:0] SLOT_DATA    = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START     = 4'd1,
    PH_BIT_LOW   = 4'd2,
    PH_BIT_HIGH  = 4'd3,
    PH_ACK_LOW   = 4'd4,
    PH_ACK_HIGH  = 4'd5,
    PH_STOP_LOW  = 4'd6,
    PH_STOP_HIGH = 4'd7,
    PH_STOP_END  = 4'd8
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  bit_count;
    logic [1:0]  byte_index;
    logic [7:0]  shift_reg;
    logic [15:0] address_latch;
    logic [7:0]  data_latch;
    logic        scl;
    logic        sda;
    logic        failed;
  } state_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic [1:0] status;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:         PH_IDLE,
    bit_count:     4'd0,
    byte_index:    2'd0,
    shift_reg:     8'd0,
    address_latch: 16'd0,
    data_latch:    8'd0,
    scl:           1'b1,
    sda:           1'b1,
    failed:        1'b0
  };

  function automatic logic [7:0] byte_for(input logic [1:0] slot, input logic [6:0] dev_sel,
                                          input logic [15:0] addr, input logic [7:0] data);
    logic [7:0] b;
    case (slot)
      SLOT_DEVICE:  b = {dev_sel, WRITE_BIT};
      SLOT_ADDR_HI: b = addr[15:8];
      SLOT_ADDR_LO: b = addr[7:0];
      SLOT_DATA:    b = data;
      default:      b = data;
    endcase
    return b;
  endfunction

endpackage

// File: sv/i2c_eeprom_byte_write_master.sv
// I2C master for a single EEPROM byte write, stepped one half-bit bus phase per item.
// Input channel (in_valid / in_stall): kind = 1 starts a write with mem_address and
// write_data (ignored while a write is in progress); kind = 0 is one half-bit tick
// from an external prescaler, with sda_in the sampled data line for acknowledges.
// Every accepted input transfer yields exactly one result transfer on the output
// channel (out_valid / out_stall): scl_level, sda_level, busy_res and status
// (1 = write done, 2 = aborted on NACK, reported on the tick that releases SDA).
// Configuration channel (cfg_valid / cfg_ready, always ready): cfg_data loads the
// seven-bit device select, sampled when a write command is taken; write it idle.
// Each result is registered in the output register. Throughput: one item per cycle
// while in_stall is low; the phase state update is a single pass of logic between the
// state register and the output register.
// Reset (rst, synchronous): bus lines released high, idle, device select 80,
// output empty.
// Receiver stall: the result is held in the output register and one more result
// parks in a skid register; in_stall rises only while that skid register is full.
module i2c_eeprom_byte_write_master (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [15:0] mem_address,
  input  logic [7:0]  write_data,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_level,
  output logic        sda_level,
  output logic        busy_res,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);
  import i2cebw_pkg::*;

  state_t     st;
  state_t     st_next;
  result_t    step_res;
  result_t    out_res;
  logic [6:0] dev_sel;
  logic       in_accept;
  logic       buf_full;

  // configuration register is always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_sel <= DEV_SEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dev_sel <= cfg_data;
    end
  end

  // stall only when the skid stage holds a result
  assign in_stall  = buf_full;
  assign in_accept = in_valid && !in_stall;

  i2cebw_step u_step (
    .st          (st),
    .dev_sel     (dev_sel),
    .kind        (kind),
    .mem_address (mem_address),
    .write_data  (write_data),
    .sda_in      (sda_in),
    .st_next     (st_next),
    .res         (step_res)
  );

  // advance the bus state only on an accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (in_accept) begin
      st <= st_next;
    end
  end

  i2cebw_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept),
    .push_data (step_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign scl_level = out_res.scl_level;
  assign sda_level = out_res.sda_level;
  assign busy_res  = out_res.busy_res;
  assign status    = out_res.status;

endmodule

// File: sv/i2cebw_step.sv
module i2cebw_step (
  input  i2cebw_pkg::state_t  st,
  input  logic [6:0]          dev_sel,
  input  logic                kind,
  input  logic [15:0]         mem_address,
  input  logic [7:0]          write_data,
  input  logic                sda_in,
  output i2cebw_pkg::state_t  st_next,
  output i2cebw_pkg::result_t res
);
  import i2cebw_pkg::*;

  logic [3:0] bit_count_inc;

  assign bit_count_inc = st.bit_count + 4'd1;

  // Next state: one half-bit phase per tick
  always_comb begin
    st_next = st;
    case (st.phase)
      PH_START: begin
        if (kind == KIND_TICK) begin
          st_next.sda   = 1'b0;
          st_next.phase = PH_BIT_LOW;
        end
      end
      PH_BIT_LOW: begin
        if (kind == KIND_TICK) begin
          st_next.scl   = 1'b0;
          st_next.sda   = st.shift_reg[7];
          st_next.phase = PH_BIT_HIGH;
        end
      end
      PH_BIT_HIGH: begin
        if (kind == KIND_TICK) begin
          st_next.scl       = 1'b1;
          st_next.shift_reg = {st.shift_reg[6:0], 1'b0};
          st_next.bit_count = bit_count_inc;
          st_next.phase     = (bit_count_inc >= 4'(BITS_PER_BYTE)) ? PH_ACK_LOW : PH_BIT_LOW;
        end
      end
      PH_ACK_LOW: begin
        if (kind == KIND_TICK) begin
          st_next.scl   = 1'b0;
          st_next.sda   = 1'b1;
          st_next.phase = PH_ACK_HIGH;
        end
      end
      PH_ACK_HIGH: begin
        if (kind == KIND_TICK) begin
          st_next.scl = 1'b1;
          if (sda_in) begin
            st_next.failed = 1'b1;
            st_next.phase  = PH_STOP_LOW;
          end else if (st.byte_index == SLOT_DATA) begin
            st_next.phase = PH_STOP_LOW;
          end else begin
            st_next.byte_index = st.byte_index + 2'd1;
            st_next.shift_reg  = byte_for(st.byte_index + 2'd1, dev_sel,
                                          st.address_latch, st.data_latch);
            st_next.bit_count  = 4'd0;
            st_next.phase      = PH_BIT_LOW;
          end
        end
      end
      PH_STOP_LOW: begin
        if (kind == KIND_TICK) begin
          st_next.scl   = 1'b0;
          st_next.sda   = 1'b0;
          st_next.phase = PH_STOP_HIGH;
        end
      end
      PH_STOP_HIGH: begin
        if (kind == KIND_TICK) begin
          st_next.scl   = 1'b1;
          st_next.phase = PH_STOP_END;
        end
      end
      PH_STOP_END: begin
        if (kind == KIND_TICK) begin
          st_next.sda   = 1'b1;
          st_next.phase = PH_IDLE;
        end
      end
      default: begin
        st_next.phase = PH_IDLE;
        if (kind == KIND_WRITE) begin
          st_next.address_latch = mem_address;
          st_next.data_latch    = write_data;
          st_next.byte_index    = SLOT_DEVICE;
          st_next.bit_count     = 4'd0;
          st_next.shift_reg     = byte_for(SLOT_DEVICE, dev_sel, mem_address, write_data);
          st_next.failed        = 1'b0;
          st_next.phase         = PH_START;
        end
      end
    endcase
  end

  // Result of this step
  always_comb begin
    res.scl_level = st_next.scl;
    res.sda_level = st_next.sda;
    res.busy_res  = (st_next.phase != PH_IDLE);
    res.status    = STATUS_NONE;
    if ((st.phase == PH_STOP_END) && (kind == KIND_TICK)) begin
      res.status = st.failed ? STATUS_NACK : STATUS_DONE;
    end
  end

endmodule

// File: sv/i2cebw_obuf.sv
module i2cebw_obuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  i2cebw_pkg::result_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cebw_pkg::result_t out_data
);
  import i2cebw_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        if (push) begin
          out_data <= push_data;
        end
      end
    end else if (push) begin
      // main stage held: park the transfer
      skid_data  <= push_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

// File: sv/i2cebw_check.sv
module i2cebw_check (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       scl_level,
  input logic       sda_level,
  input logic       busy_res,
  input logic [1:0] status
);
  import i2cebw_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({scl_level, sda_level, busy_res, status}))
    else $error("stalled result changed");

  // outcome is reported only as the transfer ends
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STATUS_NONE) |-> !busy_res)
    else $error("status reported while busy");

  // idle bus is released
  a_idle_bus: assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> scl_level && sda_level)
    else $error("bus not released while idle");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STATUS_NONE) || (status == STATUS_DONE) || (status == STATUS_NACK))
    else $error("undefined status code");

  // skid drains as soon as the receiver takes a result
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    !out_stall |=> !in_stall)
    else $error("input stalled after receiver was ready");

endmodule

bind i2c_eeprom_byte_write_master i2cebw_check u_check (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .scl_level (scl_level),
  .sda_level (sda_level),
  .busy_res  (busy_res),
  .status    (status)
);

// File: bench/i2c_eeprom_byte_write_master_test.sv
`timescale 1ns / 100ps

module i2c_eeprom_byte_write_master_test;
  import i2cebw_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int ITEM_GOAL      = 1550;
  localparam int PHASE_COUNT    = 5;
  // One byte on the bus: 8 bits of two half-bit ticks each, then ack low and ack high.
  localparam int TICKS_PER_BYTE = 18;
  localparam int STOP_TICKS     = 3;
  localparam int NO_NACK        = 4;
  localparam int PRINT_CAP      = 40;

  localparam result_t LINES_IDLE = '{1'b1, 1'b1, 1'b0, STATUS_NONE};

  // Stimulus row of the directed part; want is used only where pinned is set.
  typedef struct {
    logic        k;
    logic [15:0] a;
    logic [7:0]  d;
    logic        line;
    bit          pinned;
    result_t     want;
  } stim_row_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        kind        = KIND_TICK;
  logic [15:0] mem_address = '0;
  logic [7:0]  write_data  = '0;
  logic        sda_in      = 1'b1;
  logic        out_stall   = 1'b0;
  logic        cfg_valid   = 1'b0;
  logic [6:0]  cfg_data    = '0;
  wire         in_stall;
  wire         out_valid;
  wire         scl_level;
  wire         sda_level;
  wire         busy_res;
  wire  [1:0]  status;
  wire         cfg_ready;

  // Side-band that travels with the payload: a typed-in expectation for table rows.
  logic        row_pinned  = 1'b0;
  result_t     row_result  = '0;

  // Bus-master prediction state, advanced once per accepted input transfer.
  phase_t      bus_phase;
  logic [3:0]  bits_sent;
  logic [1:0]  slot;
  logic [7:0]  shifter;
  logic [15:0] addr_held;
  logic [7:0]  data_held;
  logic        scl_now;
  logic        sda_now;
  logic        nack_seen;
  logic [6:0]  dev_sel;

  result_t     bus_levels_due[$];
  stim_row_t   directed_rows[$];

  bit          idle_on = 1'b1;
  int          stall_left;
  int          cycle_count;
  int          fail_count;
  int          items_sent;
  int          commands_sent;
  int          results_checked;
  int          writes_done;
  int          writes_nacked;
  int          cfg_writes;

  i2c_eeprom_byte_write_master dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .mem_address (mem_address),
    .write_data  (write_data),
    .sda_in      (sda_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .scl_level   (scl_level),
    .sda_level   (sda_level),
    .busy_res    (busy_res),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Byte that goes on the wire for a given slot of the write.
  function automatic logic [7:0] slot_byte(input logic [1:0] s);
    case (s)
      SLOT_DEVICE:  return {dev_sel, WRITE_BIT};
      SLOT_ADDR_HI: return addr_held[15:8];
      SLOT_ADDR_LO: return addr_held[7:0];
      default:      return data_held;
    endcase
  endfunction

  // Advance the predicted bus by one input item and return the line levels after it.
  function automatic result_t step_bus(input logic k, input logic [15:0] a,
                                       input logic [7:0] d, input logic line);
    result_t    r;
    logic [1:0] st;
    st = STATUS_NONE;
    if (bus_phase == PH_IDLE) begin
      // Idle: latch a command, ignore a tick; lines do not move on this item.
      if (k == KIND_WRITE) begin
        addr_held = a;
        data_held = d;
        slot      = SLOT_DEVICE;
        bits_sent = '0;
        nack_seen = 1'b0;
        shifter   = slot_byte(SLOT_DEVICE);
        bus_phase = PH_START;
      end
    end else if (k == KIND_TICK) begin
      // Busy: only ticks advance; a command in flight is dropped.
      case (bus_phase)
        PH_START: begin
          sda_now   = 1'b0;
          bus_phase = PH_BIT_LOW;
        end
        PH_BIT_LOW: begin
          scl_now   = 1'b0;
          sda_now   = shifter[7];
          bus_phase = PH_BIT_HIGH;
        end
        PH_BIT_HIGH: begin
          scl_now   = 1'b1;
          shifter   = shifter << 1;
          bits_sent = bits_sent + 4'd1;
          bus_phase = (bits_sent >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_BIT_LOW;
        end
        PH_ACK_LOW: begin
          scl_now   = 1'b0;
          sda_now   = 1'b1;
          bus_phase = PH_ACK_HIGH;
        end
        PH_ACK_HIGH: begin
          scl_now = 1'b1;
          if (line) begin
            nack_seen = 1'b1;
            bus_phase = PH_STOP_LOW;
          end else if (slot == SLOT_DATA) begin
            bus_phase = PH_STOP_LOW;
          end else begin
            slot      = slot + 2'd1;
            shifter   = slot_byte(slot);
            bits_sent = '0;
            bus_phase = PH_BIT_LOW;
          end
        end
        PH_STOP_LOW: begin
          scl_now   = 1'b0;
          sda_now   = 1'b0;
          bus_phase = PH_STOP_HIGH;
        end
        PH_STOP_HIGH: begin
          scl_now   = 1'b1;
          bus_phase = PH_STOP_END;
        end
        default: begin
          sda_now   = 1'b1;
          st        = nack_seen ? STATUS_NACK : STATUS_DONE;
          bus_phase = PH_IDLE;
        end
      endcase
    end
    r.scl_level = scl_now;
    r.sda_level = sda_now;
    r.busy_res  = (bus_phase != PH_IDLE);
    r.status    = st;
    return r;
  endfunction

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= PRINT_CAP) $display("%0t ns: %s", $time, msg);
  endtask

  // Predict on every accepted input transfer, check every accepted result transfer.
  // Check before predicting: a result never belongs to an input taken at the same edge.
  always @(posedge clk) begin : track
    result_t want;
    result_t predicted;
    if (rst) begin
      bus_phase = PH_IDLE;
      bits_sent = '0;
      slot      = SLOT_DEVICE;
      shifter   = '0;
      addr_held = '0;
      data_held = '0;
      scl_now   = 1'b1;
      sda_now   = 1'b1;
      nack_seen = 1'b0;
      dev_sel   = DEV_SEL_RESET;
    end else begin
      if (cfg_valid && cfg_ready) dev_sel = cfg_data;
      if (out_valid && !out_stall) begin
        if (bus_levels_due.size() == 0) begin
          report_failure("result transfer with no input outstanding");
        end else begin
          want = bus_levels_due.pop_front();
          results_checked++;
          if (status == STATUS_DONE) writes_done++;
          if (status == STATUS_NACK) writes_nacked++;
          if (scl_level !== want.scl_level)
            report_failure($sformatf("scl_level %b, expected %b", scl_level, want.scl_level));
          if (sda_level !== want.sda_level)
            report_failure($sformatf("sda_level %b, expected %b", sda_level, want.sda_level));
          if (busy_res !== want.busy_res)
            report_failure($sformatf("busy_res %b, expected %b", busy_res, want.busy_res));
          if (status !== want.status)
            report_failure($sformatf("status %0d, expected %0d", status, want.status));
        end
      end
      if (in_valid && !in_stall) begin
        predicted = step_bus(kind, mem_address, write_data, sda_in);
        bus_levels_due.push_back(row_pinned ? row_result : predicted);
      end
    end
  end

  // Receiver side: stall in random bursts while idling is on.
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_row(input logic k, input logic [15:0] a, input logic [7:0] d,
                         input logic line, input bit pinned, input result_t want);
    stim_row_t row;
    row.k      = k;
    row.a      = a;
    row.d      = d;
    row.line   = line;
    row.pinned = pinned;
    row.want   = want;
    directed_rows.push_back(row);
  endtask

  // Offer one item and hold it until it is taken. An idle burst drops valid first;
  // back-to-back items keep valid high with a single assignment per edge.
  task automatic send_item(input logic k, input logic [15:0] a, input logic [7:0] d,
                           input logic line, input bit pinned, input result_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    mem_address <= a;
    write_data  <= d;
    sda_in      <= line;
    row_pinned  <= pinned;
    row_result  <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (k == KIND_WRITE) commands_sent++;
  endtask

  task automatic write_device_select(input logic [6:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // Drop valid and wait until every outstanding result has been seen, plus a margin.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (bus_levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One well-formed write: command, then exactly the ticks the bus needs to finish.
  // Acks are low unless a NACK byte is picked; other ticks carry random sda_in, and a
  // stray command now and then lands while busy and must be ignored.
  task automatic run_write(input logic [15:0] a, input logic [7:0] d);
    int   nack_byte;
    int   total;
    logic line;
    nack_byte = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : NO_NACK;
    total = ((nack_byte == NO_NACK) ? 4 : nack_byte + 1) * TICKS_PER_BYTE + 1 + STOP_TICKS;
    send_item(KIND_WRITE, a, d, 1'($urandom_range(0, 1)), 1'b0, '0);
    for (int t = 0; t < total; t++) begin
      if ($urandom_range(0, 39) == 0)
        send_item(KIND_WRITE, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'b0, '0);
      if (t != 0 && t % TICKS_PER_BYTE == 0 && t <= 4 * TICKS_PER_BYTE)
        line = (t / TICKS_PER_BYTE - 1 == nack_byte);
      else
        line = 1'($urandom_range(0, 1));
      send_item(KIND_TICK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                line, 1'b0, '0);
    end
  endtask

  initial begin
    int         txn;
    logic [6:0] sel;

    // Directed part: idle ticks, a command and a command while busy, then the device
    // byte shifted out and a NACK on its ack, which aborts through a stop.
    add_row(KIND_TICK,  16'h0000, 8'h00, 1'b1, 1'b1, LINES_IDLE);
    add_row(KIND_TICK,  16'hFFFF, 8'hFF, 1'b0, 1'b1, LINES_IDLE);
    add_row(KIND_WRITE, 16'hFFFF, 8'hFF, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b1, STATUS_NONE});
    add_row(KIND_TICK,  16'h0000, 8'h00, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b1, STATUS_NONE});
    add_row(KIND_WRITE, 16'h0000, 8'h00, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b1, STATUS_NONE});
    for (int i = 0; i < 2 * BITS_PER_BYTE; i++)
      add_row(KIND_TICK, 16'(i * 4099), 8'(i * 17), 1'(i), 1'b0, '0);
    add_row(KIND_TICK,  16'h0000, 8'h00, 1'b0, 1'b0, '0);
    add_row(KIND_TICK,  16'h0000, 8'h00, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b1, STATUS_NONE});
    add_row(KIND_TICK,  16'h0000, 8'h00, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, STATUS_NONE});
    add_row(KIND_TICK,  16'h0000, 8'h00, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b1, STATUS_NONE});
    add_row(KIND_TICK,  16'h0000, 8'h00, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b0, STATUS_NACK});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].k, directed_rows[i].a, directed_rows[i].d,
                directed_rows[i].line, directed_rows[i].pinned, directed_rows[i].want);

    // Random part in phases, one device select each: both extremes, then random ones.
    // The last phase runs with no idling on either side.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain();
      idle_on = (p != PHASE_COUNT - 1);
      case (p)
        0:       sel = 7'h00;
        1:       sel = 7'h7F;
        default: sel = 7'($urandom_range(0, 127));
      endcase
      write_device_select(sel);
      txn = 0;
      while (items_sent < ITEM_GOAL * (p + 1) / PHASE_COUNT) begin
        if (p == 0 && txn == 0)
          run_write(16'hFFFF, 8'hFF);
        else if (p == 0 && txn == 1)
          run_write(16'h0000, 8'h00);
        else
          run_write(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        // Stray ticks between writes must leave the bus released.
        if ($urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 3))
            send_item(KIND_TICK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'b0, '0);
        txn++;
      end
    end

    drain();
    $display("Drove %0d items, %0d of them write commands, under %0d device-select settings.",
             items_sent, commands_sent, cfg_writes + 1);
    $display("Checked %0d results: %0d writes completed, %0d aborted on a missing ack.",
             results_checked, writes_done, writes_nacked);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: i2c_eeprom_byte_write_master.f
sv/i2cebw_pkg.sv
sv/i2cebw_step.sv
sv/i2cebw_obuf.sv
sv/i2c_eeprom_byte_write_master.sv
sv/i2cebw_check.sv
bench/i2c_eeprom_byte_write_master_test.sv
